// File: sv/ujs_pkg.sv
// Package for the UTF-8 symbol swap unit: symbol tables and shared types.
// Used by ujs_match and utf8_jis_ms_symbol_swap_unit; depends on nothing.
package ujs_pkg;

    localparam int SYM_COUNT = 7;
    localparam int SYM_LEN   = 3;
    localparam int HOLD_MAX  = 2;
    localparam int OUT_MAX   = 3;

    localparam logic DIR_MS_TO_JIS = 1'b0;
    localparam logic DIR_JIS_TO_MS = 1'b1;

    localparam logic [7:0] MS_FORMS [SYM_COUNT][SYM_LEN] = '{
        '{8'hE2, 8'h80, 8'h95}, '{8'hEF, 8'hBD, 8'h9E}, '{8'hE2, 8'h88, 8'hA5},
        '{8'hEF, 8'hBC, 8'h8D}, '{8'hEF, 8'hBF, 8'hA0}, '{8'hEF, 8'hBF, 8'hA1},
        '{8'hEF, 8'hBF, 8'hA2}
    };
    localparam logic [1:0] MS_LENS [SYM_COUNT] = '{
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
    };

    localparam logic [7:0] JIS_FORMS [SYM_COUNT][SYM_LEN] = '{
        '{8'hE2, 8'h80, 8'h94}, '{8'hE3, 8'h80, 8'h9C}, '{8'hE2, 8'h80, 8'h96},
        '{8'hE2, 8'h88, 8'h92}, '{8'hC2, 8'hA2, 8'h00}, '{8'hC2, 8'hA3, 8'h00},
        '{8'hC2, 8'hAC, 8'h00}
    };
    localparam logic [1:0] JIS_LENS [SYM_COUNT] = '{
        2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2
    };

    typedef struct packed {
        logic       full;
        logic       prefix;
        logic [2:0] which;
    } cls_t;

    typedef struct packed {
        logic [OUT_MAX-1:0][7:0]  bytes;
        logic [1:0]               count;
        logic [1:0]               held_count;
        logic [HOLD_MAX-1:0][7:0] held_bytes;
    } match_res_t;

endpackage

// File: sv/ujs_match.sv
// Combinational matcher: joins held bytes with the new item and yields results.
// Depends on ujs_pkg for the symbol tables and the result struct.
module ujs_match (
    input  logic                              dir,
    input  logic [7:0]                        in_byte,
    input  logic                              in_final,
    input  logic [1:0]                        held_count,
    input  logic [ujs_pkg::HOLD_MAX-1:0][7:0] held_bytes,
    output ujs_pkg::match_res_t               res
);
    import ujs_pkg::*;

    function automatic cls_t classify(input logic dir_i, input logic [7:0] s0,
                                      input logic [7:0] s1, input logic [7:0] s2,
                                      input logic [1:0] n);
        cls_t       r;
        logic [1:0] len;
        logic       ok;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] p2;
        r = '0;
        for (int i = 0; i < SYM_COUNT; i++) begin
            len = dir_i ? JIS_LENS[i] : MS_LENS[i];
            p0  = dir_i ? JIS_FORMS[i][0] : MS_FORMS[i][0];
            p1  = dir_i ? JIS_FORMS[i][1] : MS_FORMS[i][1];
            p2  = dir_i ? JIS_FORMS[i][2] : MS_FORMS[i][2];
            ok  = (n <= len);
            if (n >= 2'd1 && s0 != p0) begin
                ok = 1'b0;
            end
            if (n >= 2'd2 && s1 != p1) begin
                ok = 1'b0;
            end
            if (n >= 2'd3 && s2 != p2) begin
                ok = 1'b0;
            end
            if (ok) begin
                if (n == len) begin
                    if (!r.full) begin
                        r.full  = 1'b1;
                        r.which = 3'(i);
                    end
                end else begin
                    r.prefix = 1'b1;
                end
            end
        end
        return r;
    endfunction

    logic [7:0]         seq [SYM_LEN];
    logic [1:0]         n;
    logic [1:0]         oc;
    logic               done;
    cls_t               cls;
    logic [1:0]         dst_len;
    logic [OUT_MAX-1:0][7:0] ob;

    always_comb begin
        seq[0] = in_byte;
        seq[1] = in_byte;
        seq[2] = in_byte;
        unique case (held_count)
            2'd0: begin
                n = 2'd1;
            end
            2'd1: begin
                seq[0] = held_bytes[0];
                n      = 2'd2;
            end
            default: begin
                seq[0] = held_bytes[0];
                seq[1] = held_bytes[1];
                n      = 2'd3;
            end
        endcase

        oc      = 2'd0;
        done    = 1'b0;
        ob      = '0;
        cls     = '0;
        dst_len = 2'd0;
        for (int it = 0; it < SYM_LEN; it++) begin
            if (!done && n != 2'd0) begin
                cls = classify(dir, seq[0], seq[1], seq[2], n);
                if (cls.full) begin
                    dst_len = dir ? MS_LENS[cls.which] : JIS_LENS[cls.which];
                    for (int k = 0; k < SYM_LEN; k++) begin
                        if (k < int'(dst_len) && oc < 2'd3) begin
                            ob[oc] = dir ? MS_FORMS[cls.which][k] : JIS_FORMS[cls.which][k];
                            oc     = oc + 2'd1;
                        end
                    end
                    n    = 2'd0;
                    done = 1'b1;
                end else if (cls.prefix) begin
                    done = 1'b1;
                end else begin
                    if (oc < 2'd3) begin
                        ob[oc] = seq[0];
                        oc     = oc + 2'd1;
                    end
                    seq[0] = seq[1];
                    seq[1] = seq[2];
                    n      = n - 2'd1;
                end
            end
        end

        if (in_final) begin
            for (int k = 0; k < HOLD_MAX; k++) begin
                if (k < int'(n) && oc < 2'd3) begin
                    ob[oc] = seq[k];
                    oc     = oc + 2'd1;
                end
            end
            n = 2'd0;
        end

        res.bytes         = ob;
        res.count         = oc;
        res.held_count    = n;
        res.held_bytes[0] = seq[0];
        res.held_bytes[1] = seq[1];
    end

endmodule

// File: sv/utf8_jis_ms_symbol_swap_unit.sv
// Top level of the UTF-8 symbol swap unit: stream ports, direction register,
// held-byte state and the result group register. Depends on ujs_pkg, ujs_match.
//
// Usage: bytes of UTF-8 text enter on the s_ channel, one item per byte, with
// s_tlast high on the last byte of a text. Results leave on the m_ channel one
// byte per item; m_tlast marks the last result caused by one input byte and
// m_tuser marks the last result of the whole text. An input byte that only
// extends a partial symbol match causes no result. The direction is written
// through the cfg_ channel; the user must do so only while the unit is idle,
// which the unit does not enforce: 0 maps Microsoft symbol forms to JIS forms,
// 1 maps the other way. An accepted byte's first result appears in the next
// cycle. An input byte causes up to three results, which leave one per cycle
// from the result group register; a new byte is accepted in the cycle the last
// of the previous group is taken, so one byte per cycle is sustained while each
// byte causes at most one result. When the receiver stalls, the group register
// holds and s_tready falls once the group cannot drain. Reset clears the held
// partial match, empties the group register and sets the direction to 0.
module utf8_jis_ms_symbol_swap_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_end
    output logic       m_tuser,   // [0] out_final
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import ujs_pkg::*;

    logic                     dir_reg;
    logic [1:0]               held_count_reg;
    logic [HOLD_MAX-1:0][7:0] held_bytes_reg;
    logic [OUT_MAX-1:0][7:0]  grp_bytes_reg;
    logic [1:0]               grp_count_reg;
    logic [1:0]               grp_idx_reg;
    logic [1:0]               grp_idx_next;
    logic                     grp_final_reg;
    logic                     grp_valid_reg;
    logic                     grp_valid_next;
    logic                     grp_last;
    logic                     s_accept;
    logic                     m_accept;
    match_res_t               res;

    ujs_match u_match (
        .dir        (dir_reg),
        .in_byte    (s_tdata),
        .in_final   (s_tlast),
        .held_count (held_count_reg),
        .held_bytes (held_bytes_reg),
        .res        (res)
    );

    assign cfg_ready = 1'b1;
    assign grp_last  = (grp_idx_reg == grp_count_reg - 2'd1);
    assign m_accept  = m_tvalid && m_tready;
    assign s_tready  = !grp_valid_reg || (m_tready && grp_last);
    assign s_accept  = s_tvalid && s_tready;

    assign m_tvalid = grp_valid_reg;
    assign m_tdata  = grp_bytes_reg[grp_idx_reg];
    assign m_tlast  = grp_last;
    assign m_tuser  = grp_final_reg && grp_last;

    always_comb begin
        grp_valid_next = grp_valid_reg;
        grp_idx_next   = grp_idx_reg;
        if (m_accept) begin
            if (grp_last) begin
                grp_valid_next = 1'b0;
            end else begin
                grp_idx_next = grp_idx_reg + 2'd1;
            end
        end
        if (s_accept && res.count != 2'd0) begin
            grp_valid_next = 1'b1;
            grp_idx_next   = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg        <= DIR_MS_TO_JIS;
            held_count_reg <= 2'd0;
            grp_valid_reg  <= 1'b0;
            grp_idx_reg    <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                dir_reg <= cfg_data;
            end
            if (s_accept) begin
                held_count_reg <= res.held_count;
            end
            grp_valid_reg <= grp_valid_next;
            grp_idx_reg   <= grp_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            held_bytes_reg <= res.held_bytes;
            if (res.count != 2'd0) begin
                grp_bytes_reg <= res.bytes;
                grp_count_reg <= res.count;
                grp_final_reg <= s_tlast;
            end
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_jis_ms_symbol_swap_unit: streams UTF-8 text
// with random gaps and stalls and checks every result byte against its own model.
// Depends on ujs_pkg and the unit's RTL only.
module tb_top;

    localparam int  SETTLE_CYCLES  = 4;
    localparam int  TAIL_CYCLES    = 12;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  REPORT_LIMIT   = 10;
    localparam logic SIDE_MS       = 1'b0;
    localparam logic SIDE_JIS      = 1'b1;

    typedef enum logic [1:0] {OP_BYTE, OP_DIR, OP_DRAIN} feed_kind_t;
    typedef enum int {MATCH_NONE, MATCH_PREFIX, MATCH_FULL} match_kind_t;

    typedef struct packed {
        feed_kind_t kind;
        logic [7:0] data;
        logic       last;
        logic [5:0] gap;
    } feed_op_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       fin;
    } swap_out_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    feed_op_t  text_feed [$];
    swap_out_t due_bytes [$];
    swap_out_t want;
    feed_op_t  next_op;

    logic            dir_model = ujs_pkg::DIR_MS_TO_JIS;
    int              held_n    = 0;
    logic [1:0][7:0] held_q    = '0;

    logic       s_fire = 1'b0, m_fire = 1'b0, cfg_fire = 1'b0;
    logic       presenting = 1'b0, cfg_busy = 1'b0;
    logic [7:0] tx_byte = 8'h00;
    logic       tx_last = 1'b0, cfg_value = 1'b0;
    logic       gaps_on = 1'b0, feed_done = 1'b0, timed_out = 1'b0, ready_next = 1'b0;
    int         gap_left = 0, quiet_cycles = 0, idle_cycles = 0, rx_stall = 0, rx_cycle = 0;
    int         fail_count = 0, bytes_queued = 0;

    utf8_jis_ms_symbol_swap_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Symbol tables, first byte in the top bits.
    function automatic logic [23:0] form_seq(input logic side, input int idx);
        logic [23:0] seq;
        seq = '0;
        if (side == SIDE_MS) begin
            case (idx)
                0: seq = 24'hE28095;
                1: seq = 24'hEFBD9E;
                2: seq = 24'hE288A5;
                3: seq = 24'hEFBC8D;
                4: seq = 24'hEFBFA0;
                5: seq = 24'hEFBFA1;
                default: seq = 24'hEFBFA2;
            endcase
        end else begin
            case (idx)
                0: seq = 24'hE28094;
                1: seq = 24'hE3809C;
                2: seq = 24'hE28096;
                3: seq = 24'hE28892;
                4: seq = 24'hC2A200;
                5: seq = 24'hC2A300;
                default: seq = 24'hC2AC00;
            endcase
        end
        return seq;
    endfunction

    function automatic int form_len(input logic side, input int idx);
        return (side == SIDE_JIS && idx >= 4) ? 2 : 3;
    endfunction

    function automatic logic [7:0] form_byte(input logic side, input int idx, input int pos);
        logic [23:0] seq;
        seq = form_seq(side, idx);
        return seq[23 - 8 * pos -: 8];
    endfunction

    function automatic match_kind_t classify_window(input logic side,
                                                    input logic [2:0][7:0] window,
                                                    input int n, output int hit);
        int   i, k, len;
        logic same, partial;
        partial = 1'b0;
        hit     = 0;
        for (i = 0; i < ujs_pkg::SYM_COUNT; i++) begin
            len  = form_len(side, i);
            same = (n <= len);
            for (k = 0; k < n && k < 3; k++) begin
                if (window[k] != form_byte(side, i, k)) begin
                    same = 1'b0;
                end
            end
            if (same && n == len) begin
                hit = i;
                return MATCH_FULL;
            end
            if (same) begin
                partial = 1'b1;
            end
        end
        return partial ? MATCH_PREFIX : MATCH_NONE;
    endfunction

    // Works out the result bytes of one accepted input byte and queues them.
    task automatic swap_step(input logic [7:0] in_b, input logic in_fin);
        logic [2:0][7:0] window;
        logic [7:0]      outs [$];
        logic            src, dst;
        int              n, k, hit;
        match_kind_t     kind;
        swap_out_t       res;
        src    = (dir_model == ujs_pkg::DIR_JIS_TO_MS) ? SIDE_JIS : SIDE_MS;
        dst    = ~src;
        window = '0;
        for (k = 0; k < held_n; k++) begin
            window[k] = held_q[k];
        end
        window[held_n] = in_b;
        n = held_n + 1;
        while (n > 0) begin
            kind = classify_window(src, window, n, hit);
            if (kind == MATCH_FULL) begin
                for (k = 0; k < form_len(dst, hit); k++) begin
                    outs.push_back(form_byte(dst, hit, k));
                end
                n = 0;
            end else if (kind == MATCH_PREFIX) begin
                break;
            end else begin
                outs.push_back(window[0]);
                window = window >> 8;
                n--;
            end
        end
        if (in_fin) begin
            for (k = 0; k < n; k++) begin
                outs.push_back(window[k]);
            end
            n = 0;
        end
        held_n = n;
        for (k = 0; k < n; k++) begin
            held_q[k] = window[k];
        end
        for (k = 0; k < outs.size(); k++) begin
            res.data    = outs[k];
            res.run_end = (k == outs.size() - 1);
            res.fin     = in_fin && (k == outs.size() - 1);
            due_bytes.push_back(res);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fin);
        feed_op_t op;
        op.kind = OP_BYTE;
        op.data = b;
        op.last = fin;
        op.gap  = gaps_on ? 6'(pick_gap()) : 6'd0;
        text_feed.push_back(op);
        bytes_queued++;
    endtask

    task automatic push_symbol(input logic side, input int idx, input int cut, input logic fin);
        int k, len;
        len = (cut < form_len(side, idx)) ? cut : form_len(side, idx);
        for (k = 0; k < len; k++) begin
            push_byte(form_byte(side, idx, k), fin && k == len - 1);
        end
    endtask

    task automatic push_ctrl(input feed_kind_t kind, input logic value);
        feed_op_t op;
        op.kind = kind;
        op.data = {7'd0, value};
        op.last = 1'b0;
        op.gap  = 6'd0;
        text_feed.push_back(op);
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    initial begin : build_and_reset
        int phase, stop, pick;
        push_ctrl(OP_DIR, ujs_pkg::DIR_MS_TO_JIS);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_symbol(SIDE_MS, 0, 3, 1'b0);
        push_symbol(SIDE_MS, 4, 3, 1'b0);
        // A partial match broken by a plain byte that also ends the text.
        push_symbol(SIDE_MS, 2, 2, 1'b0);
        push_byte(8'h41, 1'b1);
        push_byte(8'hEF, 1'b1);
        // The first lead byte is released and matching resumes on the second.
        push_byte(8'hE2, 1'b0);
        push_symbol(SIDE_MS, 0, 3, 1'b0);
        // Direction changes while two bytes are held.
        push_symbol(SIDE_JIS, 0, 2, 1'b0);
        push_ctrl(OP_DRAIN, 1'b0);
        push_ctrl(OP_DIR, ujs_pkg::DIR_JIS_TO_MS);
        push_byte(8'h94, 1'b0);
        push_symbol(SIDE_JIS, 5, 2, 1'b1);
        push_symbol(SIDE_JIS, 1, 3, 1'b1);

        for (phase = 0; phase < 8; phase++) begin
            gaps_on = (phase % 3 != 1);
            if (phase < 2 || $urandom_range(0, 1) == 1) begin
                push_ctrl(OP_DIR, (phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
            end
            stop = bytes_queued + 20;
            while (bytes_queued < stop) begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    push_symbol(1'($urandom_range(0, 1)), $urandom_range(0, 6), 3,
                                $urandom_range(0, 7) == 0);
                end else if (pick < 7) begin
                    push_symbol(1'($urandom_range(0, 1)), $urandom_range(0, 6),
                                $urandom_range(1, 2), 1'b0);
                end else begin
                    push_byte(8'($urandom), pick == 9);
                end
                if ($urandom_range(0, 19) == 0) begin
                    push_ctrl(OP_DRAIN, 1'b0);
                end
            end
            if (phase % 2 == 1) begin
                push_ctrl(OP_DRAIN, 1'b0);
            end
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        s_fire   = aresetn && s_tvalid && s_tready;
        m_fire   = aresetn && m_tvalid && m_tready;
        cfg_fire = aresetn && cfg_valid && cfg_ready;
        if (s_fire) begin
            swap_step(s_tdata, s_tlast);
        end
        if (cfg_fire) begin
            dir_model = cfg_data;
        end
        if (m_fire) begin
            if (due_bytes.size() == 0) begin
                note_failure($sformatf("unexpected result: data %02h last %0b user %0b",
                                       m_tdata, m_tlast, m_tuser));
            end else begin
                want = due_bytes.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.run_end
                        || m_tuser !== want.fin) begin
                    note_failure($sformatf(
                        "mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b (data/last/user)",
                        want.data, want.run_end, want.fin, m_tdata, m_tlast, m_tuser));
                end
            end
        end
        if (aresetn) begin
            if (s_fire || m_fire || cfg_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
            end
        end
    end

    always @(negedge aclk) begin
        if (s_fire) begin
            presenting = 1'b0;
        end
        if (cfg_fire) begin
            cfg_busy = 1'b0;
        end
        if (due_bytes.size() == 0 && !presenting && !cfg_busy) begin
            quiet_cycles++;
        end else begin
            quiet_cycles = 0;
        end
        if (aresetn && !presenting && !cfg_busy) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (text_feed.size() > 0) begin
                next_op = text_feed[0];
                case (next_op.kind)
                    OP_BYTE: begin
                        next_op    = text_feed.pop_front();
                        tx_byte    = next_op.data;
                        tx_last    = next_op.last;
                        gap_left   = next_op.gap;
                        presenting = 1'b1;
                    end
                    OP_DIR: begin
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            next_op   = text_feed.pop_front();
                            cfg_value = next_op.data[0];
                            cfg_busy  = 1'b1;
                        end
                    end
                    default: begin
                        if (due_bytes.size() == 0) begin
                            next_op = text_feed.pop_front();
                        end
                    end
                endcase
            end else if (due_bytes.size() == 0) begin
                feed_done = 1'b1;
            end
        end
        s_tvalid  <= presenting;
        s_tdata   <= tx_byte;
        s_tlast   <= tx_last;
        cfg_valid <= cfg_busy;
        cfg_data  <= cfg_value;
    end

    // Receiver stalls begin only while bit 8 of rx_cycle is set, so windows with and without stalls alternate.
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_stall > 0) begin
            rx_stall--;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
            if (rx_cycle[8] && $urandom_range(0, 3) == 0) begin
                rx_stall = pick_gap();
            end
        end
        m_tready <= ready_next;
    end

    initial begin
        wait (feed_done || timed_out);
        if (!timed_out) begin
            repeat (TAIL_CYCLES) @(posedge aclk);
        end
        if (due_bytes.size() != 0) begin
            note_failure($sformatf("%0d expected result items never arrived",
                                   due_bytes.size()));
        end
        if (fail_count == 0 && !timed_out) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/ujs_pkg.sv
sv/ujs_match.sv
sv/utf8_jis_ms_symbol_swap_unit.sv
verif/tb_top.sv
